### hw/rtl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

### hw/rtl/srarq_pkg.sv
// ----------------------------------------------------------------------------
// srarq_pkg
// Shared types and codes for the selective-repeat ARQ controller.
// ----------------------------------------------------------------------------
package srarq_pkg;
    // largest sequence number; windows are (SEQ_MAX + 1) / 2 slots
    localparam int SEQ_MAX = 31;

    localparam logic [2:0] OP_NET   = 3'd0;
    localparam logic [2:0] OP_LINK  = 3'd1;
    localparam logic [2:0] OP_FRAME = 3'd2;
    localparam logic [2:0] OP_ATO   = 3'd3;
    localparam logic [2:0] OP_DTO   = 3'd4;

    localparam logic [2:0] ACT_STATUS = 3'd0;
    localparam logic [2:0] ACT_DATA   = 3'd1;
    localparam logic [2:0] ACT_NAK    = 3'd2;
    localparam logic [2:0] ACT_ACK    = 3'd3;
    localparam logic [2:0] ACT_DELIV  = 3'd4;
    localparam logic [2:0] ACT_STOP   = 3'd5;
    localparam logic [2:0] ACT_START  = 3'd6;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_NAK  = 2'd1;

    localparam logic [0:0] CFG_ACK  = 1'b0;
    localparam logic [0:0] CFG_DATA = 1'b1;

    typedef struct packed {
        logic [2:0] opcode;
        logic       crc_ok;
        logic [8:0] frame_len;
        logic [1:0] frm_type;
        logic [4:0] frame_seq;
        logic [4:0] frame_ack;
    } ev_t;
endpackage

### hw/rtl/selective_repeat_arq_controller.sv
// ----------------------------------------------------------------------------
// selective_repeat_arq_controller
// Selective-repeat ARQ send/receive window controller.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transfer (opcode and received-frame fields).
//   m_axis returns the actions caused by it, in order, tlast on the status
//   item that always ends an event. cfg_we/cfg_index/cfg_data set the ack and
//   data timer loads; the user must write them only while the block is idle,
//   since the block itself does not enforce this. An event passes through
//   the event queue and the event register before its items reach the
//   output register. The sequencer emits at most one item a cycle while
//   m_axis is not stalled; an accepted data frame yields at most 35 items
//   (sixteen deliveries and sixteen timer stops).
//   A two-entry event queue lets s_axis accept while the sequencer works.
//   A stalled m_axis holds the sequencer; the queue then fills and tready
//   drops. Reset clears windows, marks and flags; stored lengths are not
//   cleared and are read only after being written.
// ----------------------------------------------------------------------------
module selective_repeat_arq_controller
#(
    parameter int PACKET_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], crc_ok[3], frame_len[12:4], frame_type[14:13],
    // frame_seq[19:15], frame_ack[24:20]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // action[2:0], out_seq[7:3], out_ack[12:8], slot[16:13],
    // payload_len[25:17], timer_load[41:26], network_enable[42]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    srarq_pkg::ev_t in_ev, q_ev;
    logic q_valid, q_pop;

    assign in_ev.opcode    = s_axis_tdata[2:0];
    assign in_ev.crc_ok    = s_axis_tdata[3];
    assign in_ev.frame_len = s_axis_tdata[12:4];
    assign in_ev.frm_type  = s_axis_tdata[14:13];
    assign in_ev.frame_seq = s_axis_tdata[19:15];
    assign in_ev.frame_ack = s_axis_tdata[24:20];

    srarq_front u_front (
        .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_ev, .q_valid, .q_pop, .q_ev
    );

    srarq_back #(.PACKET_BYTES(PACKET_BYTES)) u_back (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_pop, .q_ev,
        .o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_data(m_axis_tdata),
        .o_last(m_axis_tlast)
    );
endmodule

### hw/rtl/srarq_front.sv
// ----------------------------------------------------------------------------
// srarq_front
// Accepts events and holds them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module srarq_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  srarq_pkg::ev_t  in_ev,
    output logic            q_valid,
    input  logic            q_pop,
    output srarq_pkg::ev_t  q_ev
);
    srarq_pkg::ev_t ent_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_ev     = ent_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, in_valid & in_ready} - {1'b0, q_pop & q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_valid && in_ready)
                wr_reg <= ~wr_reg;
            if (q_pop && q_valid)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ent_reg[wr_reg] <= in_ev;
    end
endmodule

### hw/rtl/srarq_back.sv
// ----------------------------------------------------------------------------
// srarq_back
// Sequencer that carries out one event, emitting at most one result item a cycle while its output is not stalled.
// ----------------------------------------------------------------------------
module srarq_back
#(
    parameter int PACKET_BYTES = 256
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic            q_valid,
    output logic            q_pop,
    input  srarq_pkg::ev_t  q_ev,
    output logic            o_valid,
    input  logic            o_ready,
    output logic [47:0]     o_data,
    output logic            o_last
);
    localparam int SW = $clog2(srarq_pkg::SEQ_MAX + 1);
    localparam int NS = (srarq_pkg::SEQ_MAX + 1) / 2;
    localparam int LW = $clog2(NS);
    localparam int CW = $clog2(NS + 1);
    localparam logic [SW-1:0] SMAX = SW'(srarq_pkg::SEQ_MAX);
    localparam logic [8:0] PB = 9'((PACKET_BYTES > 511) ? 511 : PACKET_BYTES);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HEAD  = 7'b0000010,
        S_DELIV = 7'b0000100,
        S_START = 7'b0001000,
        S_NAKD  = 7'b0010000,
        S_STOP  = 7'b0100000,
        S_STAT  = 7'b1000000
    } st_t;

    st_t st_reg;
    srarq_pkg::ev_t ev_reg;
    logic [15:0] ato_reg, dto_reg;
    logic [SW-1:0] sle_reg, nss_reg, rex_reg, rue_reg;
    logic [CW-1:0] oc_reg;
    logic [NS-1:0] mark_reg;
    logic [8:0] len_reg [NS];
    logic nak_reg, link_reg;
    logic [CW-1:0] dcnt_reg;

    logic ov_reg;
    logic [2:0] oa_reg;
    logic [4:0] os_reg, ok_reg;
    logic [3:0] osl_reg;
    logic [8:0] opl_reg;
    logic [15:0] ot_reg;
    logic one_reg, olast_reg;

    function automatic logic [SW-1:0] nx(input logic [SW-1:0] k);
        return (k < SMAX) ? k + 1'b1 : '0;
    endfunction
    function automatic logic inw(input logic [SW-1:0] a, b, c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    logic [SW-1:0] ackf, nakseq;
    logic bad, ofree;
    logic [LW-1:0] rs, ss;
    assign ackf   = (rex_reg == '0) ? SMAX : rex_reg - 1'b1;
    assign nakseq = (ev_reg.frame_ack[SW-1:0] == SMAX) ? '0 : ev_reg.frame_ack[SW-1:0] + 1'b1;
    assign bad    = (ev_reg.frame_len < 9'd5) || !ev_reg.crc_ok;
    assign ofree  = !ov_reg || o_ready;
    assign rs     = rex_reg[LW-1:0];
    assign ss     = sle_reg[LW-1:0];

    assign q_pop   = (st_reg == S_IDLE);
    assign o_valid = ov_reg;
    assign o_last  = olast_reg;
    assign o_data  = {5'd0, one_reg, ot_reg, opl_reg, osl_reg, ok_reg, os_reg, oa_reg};

    logic stopc;
    assign stopc = inw(sle_reg, ev_reg.frame_ack[SW-1:0], nss_reg) && (oc_reg != '0);

    // the state emits an item this cycle (when the output register is free)
    logic fire;
    always_comb
    begin
        fire = 1'b0;
        case (st_reg)
            S_HEAD:
                case (ev_reg.opcode)
                    srarq_pkg::OP_NET:   fire = (oc_reg < CW'(NS));
                    srarq_pkg::OP_ATO,
                    srarq_pkg::OP_DTO:   fire = 1'b1;
                    srarq_pkg::OP_FRAME:
                        fire = bad ? nak_reg
                                   : (ev_reg.frm_type == srarq_pkg::KIND_DATA);
                    default:             fire = 1'b0;
                endcase
            S_DELIV:        fire = mark_reg[rs] && (dcnt_reg < CW'(NS));
            S_START, S_STAT: fire = 1'b1;
            S_NAKD:
                fire = (ev_reg.frm_type == srarq_pkg::KIND_NAK)
                       && inw(sle_reg, nakseq, nss_reg);
            S_STOP:         fire = stopc;
            default:        fire = 1'b0;
        endcase
    end

    task automatic emit(input logic [2:0] a, input logic [SW-1:0] s, input logic ak,
                        input logic [3:0] sl, input logic [8:0] pl, input logic [15:0] t);
        oa_reg <= a; os_reg <= 5'(s);
        ok_reg <= ak ? 5'(ackf) : 5'd0; osl_reg <= sl; opl_reg <= pl; ot_reg <= t;
        one_reg <= (a == srarq_pkg::ACT_STATUS) && (oc_reg < CW'(NS)) && link_reg;
        olast_reg <= (a == srarq_pkg::ACT_STATUS);
    endtask

    logic [8:0] pl;
    logic [LW-1:0] fs;
    always_comb
    begin
        pl = (ev_reg.frame_len > 9'd7) ? ev_reg.frame_len - 9'd7 : 9'd0;
        if (pl > PB)
            pl = PB;
        fs = ev_reg.frame_seq[LW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_HEAD && ofree && ev_reg.opcode == srarq_pkg::OP_FRAME && !bad
            && ev_reg.frm_type == srarq_pkg::KIND_DATA
            && inw(rex_reg, ev_reg.frame_seq[SW-1:0], rue_reg) && !mark_reg[fs])
            len_reg[fs] <= pl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ato_reg <= 16'd1000; dto_reg <= 16'd3000;
            sle_reg <= '0; nss_reg <= '0; rex_reg <= '0; rue_reg <= SW'(NS);
            oc_reg <= '0; mark_reg <= '0; nak_reg <= 1'b1; link_reg <= 1'b0;
            dcnt_reg <= '0; ov_reg <= 1'b0; ev_reg <= '0;
            oa_reg <= '0; os_reg <= '0; ok_reg <= '0; osl_reg <= '0; opl_reg <= '0;
            ot_reg <= '0; one_reg <= 1'b0; olast_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == srarq_pkg::CFG_ACK) ato_reg <= cfg_data;
                else dto_reg <= cfg_data;
            end
            if (ofree)
                ov_reg <= fire;
            case (st_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        ev_reg <= q_ev;
                        st_reg <= S_HEAD;
                    end
                S_HEAD:
                    if (ofree)
                    begin
                        case (ev_reg.opcode)
                            srarq_pkg::OP_NET:
                            begin
                                st_reg <= S_STAT;
                                if (oc_reg < CW'(NS))
                                begin
                                    oc_reg <= oc_reg + 1'b1;
                                    link_reg <= 1'b0;
                                    emit(srarq_pkg::ACT_DATA, nss_reg, 1'b1,
                                         4'(nss_reg[LW-1:0]), 9'd0, dto_reg);
                                    nss_reg <= nx(nss_reg);
                                end
                            end
                            srarq_pkg::OP_LINK:
                            begin
                                st_reg <= S_STAT;
                                link_reg <= 1'b1;
                            end
                            srarq_pkg::OP_ATO:
                            begin
                                st_reg <= S_STAT;
                                link_reg <= 1'b0;
                                emit(srarq_pkg::ACT_ACK, '0, 1'b1, 4'd0, 9'd0, 16'd0);
                            end
                            srarq_pkg::OP_DTO:
                            begin
                                st_reg <= S_STAT;
                                link_reg <= 1'b0;
                                emit(srarq_pkg::ACT_DATA, sle_reg, 1'b1, 4'(ss), 9'd0,
                                     dto_reg);
                            end
                            srarq_pkg::OP_FRAME:
                                if (bad)
                                begin
                                    st_reg <= S_STAT;
                                    if (nak_reg)
                                    begin
                                        nak_reg <= 1'b0; link_reg <= 1'b0;
                                        emit(srarq_pkg::ACT_NAK, '0, 1'b1, 4'd0, 9'd0,
                                             16'd0);
                                    end
                                end
                                else if (ev_reg.frm_type == srarq_pkg::KIND_DATA)
                                begin
                                    if (ev_reg.frame_seq[SW-1:0] != rex_reg && nak_reg)
                                    begin
                                        nak_reg <= 1'b0; link_reg <= 1'b0;
                                        emit(srarq_pkg::ACT_NAK, '0, 1'b1, 4'd0,
                                             9'd0, 16'd0);
                                    end
                                    else
                                        emit(srarq_pkg::ACT_START, '0, 1'b0, 4'd0,
                                             9'd0, ato_reg);
                                    dcnt_reg <= '0;
                                    if (inw(rex_reg, ev_reg.frame_seq[SW-1:0], rue_reg)
                                        && !mark_reg[fs])
                                    begin
                                        mark_reg[fs] <= 1'b1;
                                        st_reg <= S_DELIV;
                                    end
                                    else
                                        st_reg <= S_NAKD;
                                end
                                else
                                    st_reg <= S_NAKD;
                            default: st_reg <= S_STAT;
                        endcase
                    end
                S_DELIV:
                    if (ofree)
                    begin
                        if (mark_reg[rs] && dcnt_reg < CW'(NS))
                        begin
                            emit(srarq_pkg::ACT_DELIV, rex_reg, 1'b0, 4'(rs),
                                 len_reg[rs], 16'd0);
                            nak_reg <= 1'b1; mark_reg[rs] <= 1'b0;
                            rex_reg <= nx(rex_reg); rue_reg <= nx(rue_reg);
                            dcnt_reg <= dcnt_reg + 1'b1;
                        end
                        else
                            st_reg <= (dcnt_reg != '0) ? S_START : S_NAKD;
                    end
                S_START:
                    if (ofree)
                    begin
                        emit(srarq_pkg::ACT_START, '0, 1'b0, 4'd0, 9'd0, ato_reg);
                        st_reg <= S_NAKD;
                    end
                S_NAKD:
                    if (ofree)
                    begin
                        if (ev_reg.frm_type == srarq_pkg::KIND_NAK
                            && inw(sle_reg, nakseq, nss_reg))
                        begin
                            link_reg <= 1'b0;
                            emit(srarq_pkg::ACT_DATA, nakseq, 1'b1, 4'(nakseq[LW-1:0]),
                                 9'd0, dto_reg);
                        end
                        st_reg <= S_STOP;
                    end
                S_STOP:
                    if (ofree)
                    begin
                        if (stopc)
                        begin
                            oc_reg <= oc_reg - 1'b1;
                            emit(srarq_pkg::ACT_STOP, sle_reg, 1'b0, 4'(ss), 9'd0, 16'd0);
                            sle_reg <= nx(sle_reg);
                        end
                        else
                            st_reg <= S_STAT;
                    end
                S_STAT:
                    if (ofree)
                    begin
                        emit(srarq_pkg::ACT_STATUS, '0, 1'b0, 4'd0, 9'd0, 16'd0);
                        st_reg <= S_IDLE;
                    end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/srarq_checker.sv
// ----------------------------------------------------------------------------
// srarq_checker
// Port-level checks for the ARQ controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module srarq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    logic is_stat, ne_set, stall;
    assign is_stat = (m_axis_tdata[2:0] == srarq_pkg::ACT_STATUS);
    assign ne_set  = m_axis_tdata[42];
    assign stall   = m_axis_tvalid && !m_axis_tready;

    `ASSERT_IMPL(a_last_status, clk, rst_n, m_axis_tvalid && m_axis_tlast, is_stat)
    `ASSERT_IMPL(a_status_last, clk, rst_n, m_axis_tvalid && is_stat, m_axis_tlast)
    `ASSERT_IMPL(a_ne_status, clk, rst_n, m_axis_tvalid && ne_set, m_axis_tlast)
    `ASSERT_NEXT(a_hold, clk, rst_n, stall, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind selective_repeat_arq_controller srarq_checker u_chk (.*);
